@@ hdl/clcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// clcrc_pkg: shared types and constants of the camera line crop unit
// beat layouts, opcodes, register indexes, conversion coefficients and buffer sizing
// ----------------------------------------------------------------------------
package clcrc_pkg;

   // buffer depth in words, the widths that follow from it and the other field widths
   localparam int BUFFER_WORDS = 512;
   localparam int POS_W        = $clog2(BUFFER_WORDS + 1);
   localparam int KEPT_W       = 10;
   localparam int SUM_W        = ((POS_W > KEPT_W) ? POS_W : KEPT_W) + 1;
   localparam int ADDR_W       = 9;
   localparam int COORD_W      = 9;
   localparam int LINES_W      = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};

   // conversion coefficients, 16 fractional bits
   localparam logic signed [25:0] COEF_RV = 26'sd91881;
   localparam logic signed [25:0] COEF_GV = 26'sd46793;
   localparam logic signed [25:0] COEF_GU = 26'sd22544;
   localparam logic signed [25:0] COEF_BU = 26'sd116129;
   localparam logic [7:0]         CHROMA_BIAS = 8'd128;
   localparam logic [15:0]        PIXEL_OPAQUE = 16'h8000;

   typedef enum logic [1:0] {
      OP_WORD        = 2'd0,
      OP_FRAME_START = 2'd1,
      OP_CLEAR       = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CROP_ENABLE     = 3'd0,
      CSR_CONVERT_RGB     = 3'd1,
      CSR_CROP_X_START    = 3'd2,
      CSR_CROP_X_END      = 3'd3,
      CSR_CROP_Y_START    = 3'd4,
      CSR_CROP_Y_END      = 3'd5,
      CSR_LINES_PER_BLOCK = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        pixel_word;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] line_number;
      logic               line_end;
   } req_beat_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_addr;
      logic [31:0]       write_data;
      logic              block_ready;
      logic              overflow;
   } rsp_beat_type;

endpackage

@@ hdl/camera_line_crop_rgb_convert_unit.sv @@
// ----------------------------------------------------------------------------
// camera_line_crop_rgb_convert_unit: camera word crop, convert and placement
// crops YUYV camera words to a window, optionally converts them to RGB555
// and assigns each kept word a line buffer address with block accounting
// ----------------------------------------------------------------------------
// pipeline: an accepted request beat passes the input register, then the
//   response register; throughput: one beat per cycle unless the response
//   side stalls; the combinational compute stage updates the position state
//   and loads the response register in the same edge
// reset: synchronous, active high; clears the registers, the position state
//   and the overflow flag; no clearing pass, the unit is usable at once
module camera_line_crop_rgb_convert_unit
   import clcrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_beat_type           req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_beat_type           rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // one YUYV sample to RGB555 with the shared chroma terms
   function automatic logic [4:0] clamp_top5(input logic signed [11:0] ch);
      logic [4:0] res;
      if (ch < 0) begin
         res = 5'd0;
      end else if (ch > 12'sd255) begin
         res = 5'h1F;
      end else begin
         res = ch[7:3];
      end
      return res;
   endfunction

   function automatic logic [15:0] make_pixel(input logic [7:0] y,
                                              input logic signed [9:0] r_off,
                                              input logic signed [9:0] gv_off,
                                              input logic signed [9:0] gu_off,
                                              input logic signed [9:0] b_off);
      logic signed [11:0] ys;
      logic signed [11:0] r_ch;
      logic signed [11:0] g_ch;
      logic signed [11:0] b_ch;
      ys   = $signed({4'b0000, y});
      r_ch = ys + 12'(r_off);
      g_ch = ys - 12'(gv_off) - 12'(gu_off);
      b_ch = ys + 12'(b_off);
      return PIXEL_OPAQUE | {1'b0, clamp_top5(b_ch), clamp_top5(g_ch), clamp_top5(r_ch)};
   endfunction

   // configuration registers
   logic               crop_enable_ff;
   logic               convert_rgb_ff;
   logic [COORD_W-1:0] crop_x_start_ff;
   logic [COORD_W-1:0] crop_x_end_ff;
   logic [COORD_W-1:0] crop_y_start_ff;
   logic [COORD_W-1:0] crop_y_end_ff;
   logic [LINES_W-1:0] lines_per_block_ff;

   // position state
   logic [POS_W-1:0]   write_position_ff, write_position_in;
   logic [LINES_W-1:0] lines_in_block_ff, lines_in_block_in;
   logic [KEPT_W-1:0]  kept_in_line_ff, kept_in_line_in;
   logic               overflow_ff, overflow_in;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   req_beat_type       s1_beat_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_beat_ff, rsp_beat_in;

   logic               s1_go;

   // compute stage signals
   logic               line_in;
   logic               col_in;
   logic               keep;
   logic [SUM_W-1:0]   addr_sum;
   logic               fits;
   logic               write_en;
   logic [KEPT_W-1:0]  kept_after;
   logic [SUM_W-1:0]   pos_sum;
   logic               block_done;
   logic [31:0]        word_data;

   logic [7:0]         y1, y2, u_raw, v_raw;
   logic signed [8:0]  u_s, v_s;
   logic signed [25:0] prod_rv, prod_gv, prod_gu, prod_bu;
   logic signed [9:0]  off_rv, off_gv, off_gu, off_bu;

   // ---------------------------------------------------------------------
   // configuration port: user writes it only while the unit is idle, unenforced; always ready
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_enable_ff     <= 1'b0;
         convert_rgb_ff     <= 1'b0;
         crop_x_start_ff    <= '0;
         crop_x_end_ff      <= '0;
         crop_y_start_ff    <= '0;
         crop_y_end_ff      <= '0;
         lines_per_block_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CROP_ENABLE:     crop_enable_ff     <= csr_data[0];
            CSR_CONVERT_RGB:     convert_rgb_ff     <= csr_data[0];
            CSR_CROP_X_START:    crop_x_start_ff    <= csr_data[COORD_W-1:0];
            CSR_CROP_X_END:      crop_x_end_ff      <= csr_data[COORD_W-1:0];
            CSR_CROP_Y_START:    crop_y_start_ff    <= csr_data[COORD_W-1:0];
            CSR_CROP_Y_END:      crop_y_end_ff      <= csr_data[COORD_W-1:0];
            CSR_LINES_PER_BLOCK: lines_per_block_ff <= csr_data[LINES_W-1:0];
            default: begin
               // indexes past the register list are ignored
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake: the compute stage moves whenever the response register
   // is empty or being drained; the input register refills behind it
   // ---------------------------------------------------------------------
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign s1_valid_in = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_beat_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // color conversion: chroma terms are shared by both pixels of the word
   // ---------------------------------------------------------------------
   assign y1    = s1_beat_ff.pixel_word[7:0];
   assign u_raw = s1_beat_ff.pixel_word[15:8];
   assign y2    = s1_beat_ff.pixel_word[23:16];
   assign v_raw = s1_beat_ff.pixel_word[31:24];

   assign u_s = $signed({1'b0, u_raw}) - $signed({1'b0, CHROMA_BIAS});
   assign v_s = $signed({1'b0, v_raw}) - $signed({1'b0, CHROMA_BIAS});

   assign prod_rv = 26'(v_s) * COEF_RV;
   assign prod_gv = 26'(v_s) * COEF_GV;
   assign prod_gu = 26'(u_s) * COEF_GU;
   assign prod_bu = 26'(u_s) * COEF_BU;

   // upper bits of a signed product are its floor over 2^16
   assign off_rv = $signed(prod_rv[25:16]);
   assign off_gv = $signed(prod_gv[25:16]);
   assign off_gu = $signed(prod_gu[25:16]);
   assign off_bu = $signed(prod_bu[25:16]);

   assign word_data = convert_rgb_ff ?
      {make_pixel(y2, off_rv, off_gv, off_gu, off_bu),
       make_pixel(y1, off_rv, off_gv, off_gu, off_bu)} :
      s1_beat_ff.pixel_word;

   // ---------------------------------------------------------------------
   // crop window, buffer placement and line/block accounting
   // ---------------------------------------------------------------------
   always_comb begin
      line_in = !crop_enable_ff ||
                (s1_beat_ff.line_number >= crop_y_start_ff &&
                 s1_beat_ff.line_number <= crop_y_end_ff);
      col_in  = !crop_enable_ff ||
                (s1_beat_ff.column >= crop_x_start_ff &&
                 s1_beat_ff.column <= crop_x_end_ff);
      keep    = line_in && col_in;

      addr_sum = SUM_W'(write_position_ff) + SUM_W'(kept_in_line_ff);
      fits     = addr_sum < SUM_W'(BUFFER_WORDS);
      write_en = (s1_beat_ff.opcode == OP_WORD) && keep && fits;

      // kept count including this word, saturating
      kept_after = kept_in_line_ff;
      if (write_en && kept_in_line_ff != KEPT_MAX) begin
         kept_after = kept_in_line_ff + KEPT_W'(1);
      end

      // line end appends the line, saturating at the buffer end
      pos_sum = SUM_W'(write_position_ff) + SUM_W'(kept_after);
      if (pos_sum > SUM_W'(BUFFER_WORDS)) begin
         pos_sum = SUM_W'(BUFFER_WORDS);
      end

      block_done = 1'b0;
      write_position_in = write_position_ff;
      lines_in_block_in = lines_in_block_ff;
      kept_in_line_in   = kept_in_line_ff;
      overflow_in       = overflow_ff;

      if (s1_beat_ff.opcode == OP_FRAME_START) begin
         write_position_in = '0;
         lines_in_block_in = '0;
         kept_in_line_in   = '0;
      end else if (s1_beat_ff.opcode == OP_CLEAR) begin
         overflow_in       = 1'b0;
         write_position_in = '0;
         kept_in_line_in   = '0;
      end else if (s1_beat_ff.opcode == OP_WORD) begin
         if (keep && !fits) begin
            overflow_in = 1'b1;
         end
         kept_in_line_in = kept_after;
         if (s1_beat_ff.line_end) begin
            if (line_in) begin
               if (lines_in_block_ff >= lines_per_block_ff) begin
                  block_done        = 1'b1;
                  write_position_in = '0;
                  lines_in_block_in = '0;
               end else begin
                  write_position_in = pos_sum[POS_W-1:0];
                  lines_in_block_in = lines_in_block_ff + LINES_W'(1);
               end
            end
            kept_in_line_in = '0;
         end
      end

      rsp_beat_in.write_valid = write_en;
      rsp_beat_in.write_addr  = write_en ? addr_sum[ADDR_W-1:0] : '0;
      rsp_beat_in.write_data  = write_en ? word_data : '0;
      rsp_beat_in.block_ready = block_done;
      rsp_beat_in.overflow    = overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_position_ff <= '0;
         lines_in_block_ff <= '0;
         kept_in_line_ff   <= '0;
         overflow_ff       <= 1'b0;
      end else if (s1_go) begin
         write_position_ff <= write_position_in;
         lines_in_block_ff <= lines_in_block_in;
         kept_in_line_ff   <= kept_in_line_in;
         overflow_ff       <= overflow_in;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_beat_ff;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for camera_line_crop_rgb_convert_unit
// a directed table, a back-pressure run and then random frames of camera
// words go through the request channel; every accepted beat is run through
// a local model of the crop, conversion and buffer placement; each response
// beat is compared field by field with the oldest placement still due
// ----------------------------------------------------------------------------
module tb_top;
   import clcrc_pkg::*;

   // delay from request to response in the unit, used as drain margin
   localparam int DUT_LATENCY = 2;
   // run guard limit, well above what a slow correct run takes
   localparam int LIMIT_CYCLES = 200000;
   localparam int ITEM_TARGET  = 1100;
   // the opcode value that the unit has no meaning for
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // keep the log short when the unit is badly broken
   localparam int MAX_REPORTS = 200;

   // one row of the directed part: a register write or a request beat
   typedef struct {
      logic          is_csr;
      csr_index_type csr_idx;
      logic [31:0]   csr_val;
      req_beat_type  beat;
      logic          typed;
      rsp_beat_type  want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;

   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // local copy of the unit's registers
   logic       crop_on;
   logic       rgb_on;
   logic [8:0] win_x0, win_x1, win_y0, win_y1;
   logic [3:0] block_lines_limit;

   // local copy of the placement state
   logic [9:0] buf_base;
   logic [3:0] block_lines;
   logic [9:0] line_kept;
   logic       overflow_seen;

   rsp_beat_type placements_due[$];

   int mismatch_count = 0;
   int item_count     = 0;
   int cycle_count    = 0;

   // sender burst shaping, and the long receiver hold-off request
   int burst_left     = 0;
   bit sender_steady  = 1'b0;
   int hold_request   = 0;

   camera_line_crop_rgb_convert_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // conversion arithmetic
   // ------------------------------------------------------------------------

   // product with 16 fractional bits, rounded toward minus infinity
   function automatic int scale16(input int a, input int c);
      return (a * c) >>> 16;
   endfunction

   function automatic logic [7:0] clamp_u8(input int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return 8'(x);
   endfunction

   // one pixel: five bits each of red, green, blue plus the opaque bit
   function automatic logic [15:0] rgb555_pixel(input int y, input int u, input int v);
      logic [7:0] r, g, b;
      r = clamp_u8(y + scale16(v, int'(COEF_RV)));
      g = clamp_u8(y - scale16(v, int'(COEF_GV)) - scale16(u, int'(COEF_GU)));
      b = clamp_u8(y + scale16(u, int'(COEF_BU)));
      return {1'b0, b[7:3], g[7:3], r[7:3]} | PIXEL_OPAQUE;
   endfunction

   // ------------------------------------------------------------------------
   // placement model: crop test, optional conversion, buffer address,
   // line and block accounting; updates the local state
   // ------------------------------------------------------------------------
   function automatic rsp_beat_type crop_convert_place(input req_beat_type b);
      rsp_beat_type r;
      logic         line_in, keep;
      logic [10:0]  addr_sum;
      int           u, v;
      r = '0;
      case (b.opcode)
         OP_FRAME_START: begin
            buf_base    = '0;
            block_lines = '0;
            line_kept   = '0;
         end
         OP_CLEAR: begin
            // block line count survives a clear
            overflow_seen = 1'b0;
            buf_base      = '0;
            line_kept     = '0;
         end
         OP_WORD: begin
            line_in = !crop_on ||
                      (b.line_number >= win_y0 && b.line_number <= win_y1);
            keep    = line_in &&
                      (!crop_on || (b.column >= win_x0 && b.column <= win_x1));
            if (keep) begin
               addr_sum = buf_base + line_kept;
               if (addr_sum >= BUFFER_WORDS) begin
                  // past the buffer end: dropped, sticky flag
                  overflow_seen = 1'b1;
               end else begin
                  u = int'(b.pixel_word[15:8]) - int'(CHROMA_BIAS);
                  v = int'(b.pixel_word[31:24]) - int'(CHROMA_BIAS);
                  r.write_valid = 1'b1;
                  r.write_addr  = addr_sum[ADDR_W-1:0];
                  r.write_data  = rgb_on ?
                     {rgb555_pixel(int'(b.pixel_word[23:16]), u, v),
                      rgb555_pixel(int'(b.pixel_word[7:0]), u, v)} : b.pixel_word;
                  if (line_kept != KEPT_MAX) line_kept = line_kept + 10'd1;
               end
            end
            // line accounting runs even when the last word was dropped
            if (b.line_end) begin
               if (line_in) begin
                  if (block_lines >= block_lines_limit) begin
                     r.block_ready = 1'b1;
                     buf_base      = '0;
                     block_lines   = '0;
                  end else begin
                     addr_sum = buf_base + line_kept;
                     if (addr_sum > BUFFER_WORDS) addr_sum = 11'(BUFFER_WORDS);
                     buf_base    = addr_sum[9:0];
                     block_lines = block_lines + 4'd1;
                  end
               end
               line_kept = '0;
            end
         end
         default: ;
      endcase
      r.overflow = overflow_seen;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch %s: expected 0x%08h got 0x%08h",
                  $time, what, want, got);
   endtask

   // a response beat moves when valid is high and our stall is low
   always @(posedge clock) begin : placement_check
      rsp_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (placements_due.size() == 0) begin
            report_mismatch("beat with nothing pending", 32'd0, rsp_data.write_data);
         end else begin
            want = placements_due.pop_front();
            if (rsp_data.write_valid !== want.write_valid)
               report_mismatch("write_valid", 32'(want.write_valid),
                               32'(rsp_data.write_valid));
            if (rsp_data.write_addr !== want.write_addr)
               report_mismatch("write_addr", 32'(want.write_addr),
                               32'(rsp_data.write_addr));
            if (rsp_data.write_data !== want.write_data)
               report_mismatch("write_data", want.write_data, rsp_data.write_data);
            if (rsp_data.block_ready !== want.block_ready)
               report_mismatch("block_ready", 32'(want.block_ready),
                               32'(rsp_data.block_ready));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: stretches of random length, each with its own stall style;
   // a hold-off request from the stimulus holds stall high for as long as it
   // asks, so the unit backs up and stalls its request side
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int stretch, style, k, hold_left;
      hold_left = 0;
      forever begin
         stretch = $urandom_range(16, 160);
         style   = $urandom_range(0, 3);
         for (k = 0; k < stretch; k++) begin
            @(posedge clock);
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else if (hold_request > 0) begin
               hold_left    = hold_request - 1;
               hold_request = 0;
               rsp_stall   <= 1'b1;
            end else begin
               case (style)
                  0:       rsp_stall <= 1'b0;                       // drain freely
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);  // light
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);  // heavy
                  default: rsp_stall <= k[0];                        // alternating
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // offer one request beat, hold it until taken, then log its placement;
   // between bursts the sender often drops valid for a random gap, unless steady
   task automatic send_beat(input req_beat_type beat, input logic typed,
                            input rsp_beat_type typed_want);
      rsp_beat_type want;
      int           gap;
      csr_valid <= 1'b0;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      want = crop_convert_place(beat);
      placements_due.push_back(typed ? typed_want : want);
      if (beat.opcode != OP_UNUSED) item_count++;
      if (!sender_steady) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // stop offering and let every pending beat come back
   task automatic drain_placements();
      req_valid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (DUT_LATENCY + 2) @(posedge clock);
   endtask

   // register write; valid stays up for a following write and is
   // dropped by the next request beat
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_CROP_ENABLE:     crop_on           = value[0];
         CSR_CONVERT_RGB:     rgb_on            = value[0];
         CSR_CROP_X_START:    win_x0            = value[8:0];
         CSR_CROP_X_END:      win_x1            = value[8:0];
         CSR_CROP_Y_START:    win_y0            = value[8:0];
         CSR_CROP_Y_END:      win_y1            = value[8:0];
         CSR_LINES_PER_BLOCK: block_lines_limit = value[3:0];
         default: ;
      endcase
   endtask

   function automatic logic [8:0] coord_pick();
      case ($urandom_range(0, 2))
         0:       return 9'd0;
         1:       return 9'd511;
         default: return 9'($urandom);
      endcase
   endfunction

   // one register setting per phase; style 0 lets long blocks run the
   // buffer out, 1 is a small window, 2 a full window with one-line
   // blocks, anything else random corners
   task automatic pick_settings(input int style);
      logic [8:0] x0, x1, y0, y1;
      logic       crop;
      logic [3:0] lpb;
      crop = 1'b1;
      lpb  = 4'($urandom_range(0, 15));
      x0   = 9'($urandom_range(0, 6));
      x1   = x0 + 9'($urandom_range(0, 20));
      y0   = 9'($urandom_range(0, 4));
      y1   = y0 + 9'($urandom_range(0, 12));
      case (style)
         0: begin
            crop = 1'b0;
            lpb  = 4'd15;
         end
         1: begin
            // now and then an empty window
            if ($urandom_range(0, 4) == 0) x0 = x1 + 9'd1;
            if ($urandom_range(0, 5) == 0) y0 = y1 + 9'd1;
         end
         2: begin
            x0 = 9'd0; x1 = 9'd511; y0 = 9'd0; y1 = 9'd511;
            lpb = 4'd0;
         end
         default: begin
            x0 = coord_pick(); x1 = coord_pick();
            y0 = coord_pick(); y1 = coord_pick();
         end
      endcase
      write_csr(CSR_CROP_ENABLE, 32'(crop));
      write_csr(CSR_CONVERT_RGB, 32'($urandom_range(0, 1)));
      write_csr(CSR_CROP_X_START, 32'(x0));
      write_csr(CSR_CROP_X_END, 32'(x1));
      write_csr(CSR_CROP_Y_START, 32'(y0));
      write_csr(CSR_CROP_Y_END, 32'(y1));
      write_csr(CSR_LINES_PER_BLOCK, 32'(lpb));
   endtask

   function automatic req_beat_type noise_beat();
      req_beat_type b;
      b.opcode      = 2'($urandom_range(0, 3));
      b.pixel_word  = $urandom;
      b.column      = 9'($urandom);
      b.line_number = 9'($urandom);
      b.line_end    = 1'($urandom);
      return b;
   endfunction

   // a frame: frame start, then lines of words with rising columns and a
   // line end on the last one; sprinkled with stray beats, clears and
   // lines that lose their line end
   task automatic send_frame(input int min_len, input int max_len, input int stop);
      int           n_lines, len, ln, k;
      logic         drop_end;
      logic [8:0]   col0, line_no;
      req_beat_type b;
      b = noise_beat();
      b.opcode = OP_FRAME_START;
      send_beat(b, 1'b0, '0);
      n_lines = $urandom_range(1, 20);
      line_no = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'd0;
      for (ln = 0; ln < n_lines && item_count < stop; ln++) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(max_len, 120) :
                                             $urandom_range(min_len, max_len);
         col0     = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'd0;
         drop_end = ($urandom_range(0, 9) == 0);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) send_beat(noise_beat(), 1'b0, '0);
            b.opcode      = OP_WORD;
            b.pixel_word  = $urandom;
            b.column      = col0 + 9'(k);
            b.line_number = line_no;
            b.line_end    = (k == len - 1) && !drop_end;
            send_beat(b, 1'b0, '0);
         end
         if ($urandom_range(0, 14) == 0) begin
            b = noise_beat();
            b.opcode = OP_CLEAR;
            send_beat(b, 1'b0, '0);
         end
         line_no = line_no + 9'd1;
      end
   endtask

   function automatic stim_row_type csr_row(input csr_index_type idx, input logic [31:0] value);
      stim_row_type row;
      row = '{csr_idx: CSR_CROP_ENABLE, default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = value;
      return row;
   endfunction

   function automatic stim_row_type beat_row(input logic [1:0] op, input logic [31:0] word,
                                             input logic [8:0] col, input logic [8:0] line_no,
                                             input logic lend, input logic typed,
                                             input rsp_beat_type want);
      stim_row_type row;
      row = '{csr_idx: CSR_CROP_ENABLE, default: '0};
      row.beat.opcode      = op;
      row.beat.pixel_word  = word;
      row.beat.column      = col;
      row.beat.line_number = line_no;
      row.beat.line_end    = lend;
      row.typed            = typed;
      row.want             = want;
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type directed_rows[$];
      logic         last_was_beat;
      int           phase, stop, k;
      req_beat_type b;

      // registers and placement state as they come out of reset
      crop_on = 1'b0; rgb_on = 1'b0;
      win_x0 = '0; win_x1 = '0; win_y0 = '0; win_y1 = '0;
      block_lines_limit = '0;
      buf_base = '0; block_lines = '0; line_kept = '0; overflow_seen = 1'b0;

      // reset settings: raw pass, no crop, every line closes a block
      directed_rows.push_back(beat_row(OP_WORD, 32'hFFFF_FFFF, 9'd511, 9'd511, 1'b0,
                              1'b1, '{1'b1, 9'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}));
      directed_rows.push_back(beat_row(OP_WORD, 32'h0000_0000, 9'd0, 9'd0, 1'b1,
                              1'b1, '{1'b1, 9'd1, 32'h0000_0000, 1'b1, 1'b0}));
      // unused opcode: no write, flag as it was
      directed_rows.push_back(beat_row(OP_UNUSED, 32'hFFFF_FFFF, 9'd511, 9'd511, 1'b1,
                              1'b1, '{1'b0, 9'd0, 32'd0, 1'b0, 1'b0}));
      // conversion: neutral chroma gives white and black, then chroma corners
      directed_rows.push_back(csr_row(CSR_CONVERT_RGB, 32'd1));
      directed_rows.push_back(beat_row(OP_WORD, 32'h80FF_80FF, 9'd0, 9'd0, 1'b0,
                              1'b1, '{1'b1, 9'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}));
      directed_rows.push_back(beat_row(OP_WORD, 32'h8000_8000, 9'd1, 9'd0, 1'b0,
                              1'b1, '{1'b1, 9'd1, 32'h8000_8000, 1'b0, 1'b0}));
      directed_rows.push_back(beat_row(OP_WORD, 32'hFF00_FF00, 9'd2, 9'd0, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'h00FF_00FF, 9'd3, 9'd0, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'h0000_FFFF, 9'd4, 9'd0, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'hFFFF_0000, 9'd5, 9'd0, 1'b1, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_FRAME_START, 32'h1234_5678, 9'd7, 9'd9, 1'b1,
                              1'b1, '{1'b0, 9'd0, 32'd0, 1'b0, 1'b0}));
      // crop window columns 2..5, lines 3..4, longest blocks
      directed_rows.push_back(csr_row(CSR_LINES_PER_BLOCK, 32'd15));
      directed_rows.push_back(csr_row(CSR_CROP_ENABLE, 32'd1));
      directed_rows.push_back(csr_row(CSR_CROP_X_START, 32'd2));
      directed_rows.push_back(csr_row(CSR_CROP_X_END, 32'd5));
      directed_rows.push_back(csr_row(CSR_CROP_Y_START, 32'd3));
      directed_rows.push_back(csr_row(CSR_CROP_Y_END, 32'd4));
      directed_rows.push_back(beat_row(OP_WORD, 32'hA5A5_5A5A, 9'd1, 9'd3, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'h3C3C_C3C3, 9'd2, 9'd3, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'h8040_20F0, 9'd5, 9'd3, 1'b1, 1'b0, '0));
      // line outside the window: not counted
      directed_rows.push_back(beat_row(OP_WORD, 32'h1111_2222, 9'd3, 9'd5, 1'b1, 1'b0, '0));
      // line end on a dropped column still closes the line
      directed_rows.push_back(beat_row(OP_WORD, 32'h7F80_7F80, 9'd4, 9'd4, 1'b0, 1'b0, '0));
      directed_rows.push_back(beat_row(OP_WORD, 32'hDEAD_BEEF, 9'd6, 9'd4, 1'b1, 1'b0, '0));
      // empty column window, then window corners
      directed_rows.push_back(csr_row(CSR_CROP_X_START, 32'd10));
      directed_rows.push_back(beat_row(OP_WORD, 32'hCAFE_F00D, 9'd5, 9'd3, 1'b1, 1'b0, '0));
      directed_rows.push_back(csr_row(CSR_CROP_X_START, 32'd511));
      directed_rows.push_back(csr_row(CSR_CROP_X_END, 32'd511));
      directed_rows.push_back(csr_row(CSR_CROP_Y_START, 32'd0));
      directed_rows.push_back(csr_row(CSR_CROP_Y_END, 32'd511));
      directed_rows.push_back(csr_row(CSR_LINES_PER_BLOCK, 32'd0));
      directed_rows.push_back(beat_row(OP_WORD, 32'h0F0F_F0F0, 9'd511, 9'd511, 1'b1,
                              1'b0, '0));
      directed_rows.push_back(beat_row(OP_CLEAR, 32'hFFFF_FFFF, 9'd511, 9'd511, 1'b1,
                              1'b1, '{1'b0, 9'd0, 32'd0, 1'b0, 1'b0}));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table; registers change only once the unit is empty
      last_was_beat = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            if (last_was_beat) drain_placements();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
            last_was_beat = 1'b0;
         end else begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
            last_was_beat = 1'b1;
         end
      end

      // back-pressure: receiver holds off for a long stretch while the
      // sender keeps offering beats back to back
      drain_placements();
      write_csr(CSR_CROP_ENABLE, 32'd0);
      sender_steady = 1'b1;
      hold_request  = 100;
      for (k = 0; k < 48; k++) begin
         b.opcode      = OP_WORD;
         b.pixel_word  = $urandom;
         b.column      = 9'(k);
         b.line_number = 9'd0;
         b.line_end    = (k % 12 == 11);
         send_beat(b, 1'b0, '0);
      end
      sender_steady = 1'b0;

      // random frames, one register setting per phase; each phase starts
      // with the sender paused until every pending beat is back
      for (phase = 0; item_count < ITEM_TARGET; phase++) begin
         drain_placements();
         pick_settings(phase % 4);
         stop = item_count + $urandom_range(110, 170);
         if (stop > ITEM_TARGET) stop = ITEM_TARGET;
         while (item_count < stop) begin
            if (phase % 4 == 0) send_frame(20, 60, stop);
            else send_frame(1, 24, stop);
         end
      end

      drain_placements();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
